>>> hdl/mcmc_pkg.sv
// Shared types and constants for the matrix chain min-cost core.
// No dependencies; every other file of the block except mcmc_ram imports this package.
package mcmc_pkg;

   // Result word field widths
   localparam int COST_W   = 34;
   localparam int STATUS_W = 2;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_TOO_FEW  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOO_MANY = 2'd2;

   // Saturation value of the reported cost
   localparam logic [COST_W-1:0] COST_MAX = '1;

   // Commands from controller to datapath
   typedef struct packed {
      logic store;    // store the accepted dimension word
      logic start;    // latch chain length, reset indices, open a new chain
      logic iv_rd;    // read the outer dimensions of the current interval
      logic iv_ld;    // capture outer dimensions, first split point
      logic sp_mul;   // first product, capture sub-interval costs
      logic sp_mul2;  // second product
      logic sp_acc;   // add, compare against best, step split point
      logic iv_wr;    // store interval cost, step to next interval
      logic emit;     // load the result word
   } mcmc_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic cnt_lt3;     // fewer than three dimensions stored
      logic split_last;  // current split point is the last of the interval
      logic iv_final;    // current interval is the whole chain
      logic out_free;    // result register can take a word
   } mcmc_stat_type;

endpackage

>>> hdl/mcmc_ifs.sv
// Valid/ready channel interfaces for dimension words and result words.
// Depends on mcmc_pkg for result field widths.
interface mcmc_req_if #(parameter int DIM_BITS = 10);
   logic                valid;
   logic                ready;
   logic [DIM_BITS-1:0] dimension;
   logic                last_dimension;

   modport source (output valid, output dimension, output last_dimension, input ready);
   modport sink   (input valid, input dimension, input last_dimension, output ready);
endinterface

interface mcmc_rsp_if;
   import mcmc_pkg::*;
   logic                valid;
   logic                ready;
   logic [COST_W-1:0]   min_cost;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output min_cost, output status, input ready);
   modport sink   (input valid, input min_cost, input status, output ready);
endinterface

>>> hdl/mcmc_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module mcmc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

>>> hdl/mcmc_dp.sv
// Datapath: dimension store, interval cost table, split-point evaluation,
// loop indices and the result register. Depends on mcmc_pkg and mcmc_ram.
module mcmc_dp #(
   parameter int MAX_DIMS = 16,
   parameter int DIM_BITS = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  mcmc_pkg::mcmc_cmd_type         cmd,
   output mcmc_pkg::mcmc_stat_type        stat,
   input  logic [DIM_BITS-1:0]            req_dimension,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [mcmc_pkg::COST_W-1:0]    rsp_min_cost,
   output logic [mcmc_pkg::STATUS_W-1:0]  rsp_status
);
   import mcmc_pkg::*;

   localparam int IW     = $clog2(MAX_DIMS);        // chain index
   localparam int CNT_W  = $clog2(MAX_DIMS + 1);    // dimension count
   localparam int P1W    = 2 * DIM_BITS;
   localparam int PW     = 3 * DIM_BITS;
   localparam int CW     = PW + IW;                 // full-precision interval cost
   localparam int EW     = (CW > COST_W) ? CW : COST_W;
   localparam int TW     = 2 * IW;                  // table address {row, col}
   localparam int TDEPTH = 1 << TW;

   // Chain bookkeeping
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                ovf_ff, ovf_in;
   logic [CNT_W-1:0]    n_ff, n_in;
   logic                too_few_ff, too_few_in;
   logic                ovf_lat_ff, ovf_lat_in;

   // Loop indices
   logic [IW-1:0]       a_ff, a_in;
   logic [IW-1:0]       b_ff, b_in;
   logic [IW-1:0]       s_ff, s_in;
   logic [IW-1:0]       len_ff, len_in;

   // Split evaluation
   logic [DIM_BITS-1:0] d_lo_ff, d_lo_in;
   logic [DIM_BITS-1:0] d_hi_ff, d_hi_in;
   logic [P1W-1:0]      prod1_ff, prod1_in;
   logic [PW-1:0]       prod_ff, prod_in;
   logic [CW-1:0]       lc_ff, lc_in;
   logic [CW-1:0]       rc_ff, rc_in;
   logic [CW-1:0]       best_ff, best_in;
   logic                first_ff, first_in;

   // Result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COST_W-1:0]   rsp_cost_ff, rsp_cost_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   // Memory ports
   logic                dim_we;
   logic [IW-1:0]       dim_rd_addr_a;
   logic [DIM_BITS-1:0] dim_rd_a;
   logic [DIM_BITS-1:0] dim_rd_b;
   logic [TW-1:0]       tbl_wr_addr;
   logic [TW-1:0]       tbl_rd_addr_a;
   logic [TW-1:0]       tbl_rd_addr_b;
   logic [CW-1:0]       tbl_rd_a;
   logic [CW-1:0]       tbl_rd_b;

   logic                room;
   logic [IW-1:0]       last_idx;
   logic [IW-1:0]       s_nx;
   logic                diag_end;
   logic [CW-1:0]       cand;
   logic [EW-1:0]       best_wide;
   logic [COST_W-1:0]   cost_sat;

   assign room     = (count_ff < CNT_W'(MAX_DIMS));
   assign last_idx = IW'(n_ff - CNT_W'(1));
   assign s_nx     = s_ff + IW'(1);
   assign diag_end = (b_ff == last_idx);
   assign cand     = lc_ff + rc_ff + CW'(prod_ff);

   // Saturate the final cost to the result width
   assign best_wide = EW'(best_ff);
   assign cost_sat  = (best_wide > EW'(COST_MAX)) ? COST_MAX : best_wide[COST_W-1:0];

   // Status to the controller
   assign stat.cnt_lt3    = (count_ff < CNT_W'(3));
   assign stat.split_last = (s_ff == b_ff - IW'(1));
   assign stat.iv_final   = (a_ff == IW'(1)) && diag_end;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   // Dimension store: written in arrival order, read at a-1/s and at b
   assign dim_we        = cmd.store && room;
   assign dim_rd_addr_a = cmd.iv_rd ? (a_ff - IW'(1)) : s_ff;

   mcmc_ram #(
      .WIDTH (DIM_BITS),
      .DEPTH (MAX_DIMS)
   ) u_dim_ram (
      .clock     (clock),
      .wr_en     (dim_we),
      .wr_addr   (count_ff[IW-1:0]),
      .wr_data   (req_dimension),
      .rd_addr_a (dim_rd_addr_a),
      .rd_data_a (dim_rd_a),
      .rd_addr_b (b_ff),
      .rd_data_b (dim_rd_b)
   );

   // Interval cost table: left part [a][s], right part [s+1][b]
   assign tbl_wr_addr   = {a_ff, b_ff};
   assign tbl_rd_addr_a = {a_ff, s_ff};
   assign tbl_rd_addr_b = {s_nx, b_ff};

   mcmc_ram #(
      .WIDTH (CW),
      .DEPTH (TDEPTH)
   ) u_tbl_ram (
      .clock     (clock),
      .wr_en     (cmd.iv_wr),
      .wr_addr   (tbl_wr_addr),
      .wr_data   (best_ff),
      .rd_addr_a (tbl_rd_addr_a),
      .rd_data_a (tbl_rd_a),
      .rd_addr_b (tbl_rd_addr_b),
      .rd_data_b (tbl_rd_b)
   );

   // Next-state logic
   always_comb begin
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      n_in          = n_ff;
      too_few_in    = too_few_ff;
      ovf_lat_in    = ovf_lat_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      s_in          = s_ff;
      len_in        = len_ff;
      d_lo_in       = d_lo_ff;
      d_hi_in       = d_hi_ff;
      prod1_in      = prod1_ff;
      prod_in       = prod_ff;
      lc_in         = lc_ff;
      rc_in         = rc_ff;
      best_in       = best_ff;
      first_in      = first_ff;
      rsp_cost_in   = rsp_cost_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      // Dimension words: store while there is room, else flag overflow
      if (cmd.store) begin
         if (room) begin
            count_in = count_ff + CNT_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end

      // Chain closes: latch its size, free the counters for the next chain
      if (cmd.start) begin
         n_in       = count_ff;
         too_few_in = (count_ff < CNT_W'(2));
         ovf_lat_in = ovf_ff;
         count_in   = '0;
         ovf_in     = 1'b0;
         best_in    = '0;
         a_in       = IW'(1);
         b_in       = IW'(2);
         len_in     = IW'(2);
      end

      // Outer dimensions of the interval
      if (cmd.iv_ld) begin
         d_lo_in  = dim_rd_a;
         d_hi_in  = dim_rd_b;
         s_in     = a_ff;
         first_in = 1'b1;
      end

      // Single-matrix sub-intervals cost nothing
      if (cmd.sp_mul) begin
         prod1_in = P1W'(d_lo_ff) * P1W'(dim_rd_a);
         lc_in    = (s_ff == a_ff) ? '0 : tbl_rd_a;
         rc_in    = (s_nx == b_ff) ? '0 : tbl_rd_b;
      end

      if (cmd.sp_mul2) begin
         prod_in = PW'(prod1_ff) * PW'(d_hi_ff);
      end

      // Keep the cheapest split
      if (cmd.sp_acc) begin
         if (first_ff || (cand < best_ff)) begin
            best_in = cand;
         end
         first_in = 1'b0;
         s_in     = s_nx;
      end

      // Step along the diagonal, or to the start of the next one
      if (cmd.iv_wr && !stat.iv_final) begin
         if (diag_end) begin
            len_in = len_ff + IW'(1);
            a_in   = IW'(1);
            b_in   = len_ff + IW'(1);
         end else begin
            a_in = a_ff + IW'(1);
            b_in = b_ff + IW'(1);
         end
      end

      // Result word
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_cost_in  = cost_sat;
         if (too_few_ff) begin
            rsp_status_in = STATUS_TOO_FEW;
         end else if (ovf_lat_ff) begin
            rsp_status_in = STATUS_TOO_MANY;
         end else begin
            rsp_status_in = STATUS_OK;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      too_few_ff    <= too_few_in;
      ovf_lat_ff    <= ovf_lat_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      s_ff          <= s_in;
      len_ff        <= len_in;
      d_lo_ff       <= d_lo_in;
      d_hi_ff       <= d_hi_in;
      prod1_ff      <= prod1_in;
      prod_ff       <= prod_in;
      lc_ff         <= lc_in;
      rc_ff         <= rc_in;
      best_ff       <= best_in;
      first_ff      <= first_in;
      rsp_cost_ff   <= rsp_cost_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_min_cost = rsp_cost_ff;
   assign rsp_status   = rsp_status_ff;

endmodule

>>> hdl/mcmc_ctrl.sv
// Controller: sequences word loading, the diagonal table fill and the result.
// Depends on mcmc_pkg for the command and status structs.
module mcmc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_last,
   output logic                    req_ready,
   input  mcmc_pkg::mcmc_stat_type stat,
   output mcmc_pkg::mcmc_cmd_type  cmd
);
   import mcmc_pkg::*;

   typedef enum logic [9:0] {
      ST_LOAD    = 10'b00_0000_0001,
      ST_START   = 10'b00_0000_0010,
      ST_IV_RD   = 10'b00_0000_0100,
      ST_IV_LD   = 10'b00_0000_1000,
      ST_SP_RD   = 10'b00_0001_0000,
      ST_SP_MUL  = 10'b00_0010_0000,
      ST_SP_MUL2 = 10'b00_0100_0000,
      ST_SP_ACC  = 10'b00_1000_0000,
      ST_IV_WR   = 10'b01_0000_0000,
      ST_EMIT    = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_LOAD);

   // Transitions and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               cmd.store = 1'b1;
               if (req_last) begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            cmd.start = 1'b1;
            state_in  = stat.cnt_lt3 ? ST_EMIT : ST_IV_RD;
         end
         ST_IV_RD: begin
            cmd.iv_rd = 1'b1;
            state_in  = ST_IV_LD;
         end
         ST_IV_LD: begin
            cmd.iv_ld = 1'b1;
            state_in  = ST_SP_RD;
         end
         ST_SP_RD: begin
            state_in = ST_SP_MUL;
         end
         ST_SP_MUL: begin
            cmd.sp_mul = 1'b1;
            state_in   = ST_SP_MUL2;
         end
         ST_SP_MUL2: begin
            cmd.sp_mul2 = 1'b1;
            state_in    = ST_SP_ACC;
         end
         ST_SP_ACC: begin
            cmd.sp_acc = 1'b1;
            state_in   = stat.split_last ? ST_IV_WR : ST_SP_RD;
         end
         ST_IV_WR: begin
            cmd.iv_wr = 1'b1;
            state_in  = stat.iv_final ? ST_EMIT : ST_IV_RD;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hdl/matrix_chain_min_cost_core.sv
// Matrix chain min-cost core: takes boundary dimensions one word per cycle
// and returns the least scalar-multiplication cost of the chain. Loading runs
// at one word per cycle. After the word marked last the block stops taking
// words and fills its interval cost table one diagonal at a time (skipped for
// fewer than three dimensions), using two multipliers and one add/compare
// unit on one split point at a time, then loads the result word once the
// output register is free. Each split point takes four steps: table read,
// first product, second product, add/compare. A result word waiting in the
// output register does not stop loading of the next chain. Dimensions beyond
// MAX_DIMS are dropped and flagged in status; the reported cost saturates at
// its 34-bit width. No clearing pass is needed after reset.
// Depends on mcmc_pkg, mcmc_ifs, mcmc_ram, mcmc_dp and mcmc_ctrl.
module matrix_chain_min_cost_core #(
   parameter int MAX_DIMS = 16,
   parameter int DIM_BITS = 10
) (
   input logic        clock,
   input logic        reset,
   mcmc_req_if.sink   req_chan,
   mcmc_rsp_if.source rsp_chan
);
   import mcmc_pkg::*;

   mcmc_cmd_type  cmd;
   mcmc_stat_type stat;

   // Sequencer
   mcmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last_dimension),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Storage, arithmetic and result register
   mcmc_dp #(
      .MAX_DIMS (MAX_DIMS),
      .DIM_BITS (DIM_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_dimension (req_chan.dimension),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_min_cost  (rsp_chan.min_cost),
      .rsp_status    (rsp_chan.status)
   );

endmodule

>>> dv/tb_top.sv
// Self-checking bench for matrix_chain_min_cost_core: feeds dimension chains
// and checks each cost word against an in-bench interval-table predictor.
// Depends on hdl/mcmc_pkg.sv, hdl/mcmc_ifs.sv and the core RTL.
`timescale 1ns / 1ps

module tb_top;
   import mcmc_pkg::*;

   localparam int MAX_DIMS     = 16;
   localparam int DIM_BITS     = 10;
   localparam int ITEM_TARGET  = 1800;
   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int HOLDOFF_LEN  = 6000;
   localparam int DRAIN_CYCLES = 3000;
   localparam int QUIET_FROM   = 20_000;
   localparam int QUIET_TO     = 32_000;

   typedef struct {
      logic [DIM_BITS-1:0] dimension;
      logic                last_dimension;
   } dim_word_type;

   typedef struct {
      logic [COST_W-1:0]   min_cost;
      logic [STATUS_W-1:0] status;
   } cost_word_type;

   logic clock;
   logic reset;

   mcmc_req_if #(.DIM_BITS(DIM_BITS)) req_chan ();
   mcmc_rsp_if                        rsp_chan ();

   matrix_chain_min_cost_core #(
      .MAX_DIMS(MAX_DIMS),
      .DIM_BITS(DIM_BITS)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   // Stimulus and expected-result queues
   dim_word_type  dim_words_pending[$];
   cost_word_type cost_words_due[$];
   int            words_queued;

   // Predictor state: stored chain and its interval costs
   logic [DIM_BITS-1:0] chain_dims[MAX_DIMS];
   int                  chain_len;
   logic                chain_truncated;
   longint unsigned     span_cost[MAX_DIMS][MAX_DIMS];

   int mismatch_count;
   int rsp_words_seen;
   int cycle_count;
   int holdoff_left;
   bit holdoff_done;

   // Clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Least scalar-multiplication cost over the first n stored dimensions
   function automatic longint unsigned least_chain_cost(int n);
      int              len, a, b, s;
      longint unsigned best, c;
      for (a = 0; a < n; a++) span_cost[a][a] = 0;
      for (len = 2; len < n; len++) begin
         for (a = 1; a + len <= n; a++) begin
            b = a + len - 1;
            best = '1;
            for (s = a; s < b; s++) begin
               c = span_cost[a][s] + span_cost[s+1][b]
                 + longint'(chain_dims[a-1]) * longint'(chain_dims[s])
                   * longint'(chain_dims[b]);
               if (c < best) best = c;
            end
            span_cost[a][b] = best;
         end
      end
      return span_cost[1][n-1];
   endfunction

   // Absorb one accepted dimension word; a last mark closes the chain
   task automatic take_dimension(logic [DIM_BITS-1:0] dim, logic last);
      cost_word_type   w;
      longint unsigned c;
      if (chain_len < MAX_DIMS) begin
         chain_dims[chain_len] = dim;
         chain_len++;
      end else begin
         chain_truncated = 1'b1;
      end
      if (last) begin
         if (chain_len < 2) begin
            w.min_cost = '0;
            w.status   = STATUS_TOO_FEW;
         end else begin
            c = least_chain_cost(chain_len);
            if (c > COST_MAX) c = COST_MAX;
            w.min_cost = c[COST_W-1:0];
            w.status   = chain_truncated ? STATUS_TOO_MANY : STATUS_OK;
         end
         cost_words_due.push_back(w);
         chain_len       = 0;
         chain_truncated = 1'b0;
      end
   endtask

   task automatic report_mismatch(string msg);
      if (mismatch_count < 40) $display("MISMATCH @%0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   task automatic add_word(int dim, bit last);
      dim_word_type w;
      w.dimension      = dim[DIM_BITS-1:0];
      w.last_dimension = last;
      dim_words_pending.push_back(w);
      words_queued++;
   endtask

   task automatic add_random_chain();
      int len, r, i, d;
      r = $urandom_range(99, 0);
      if (r < 8)       len = 1;
      else if (r < 18) len = $urandom_range(22, MAX_DIMS + 1);
      else             len = $urandom_range(MAX_DIMS, 2);
      for (i = 0; i < len; i++) begin
         r = $urandom_range(99, 0);
         if (r < 10)      d = 1023;
         else if (r < 18) d = $urandom_range(3, 1);
         else if (r < 21) d = 0;
         else             d = $urandom_range(1023, 1);
         add_word(d, i == len - 1);
      end
   endtask

   // Idle roll shared by both sides; none during the quiet window
   function automatic bit idle_now();
      if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) return 1'b0;
      return $urandom_range(99, 0) < 32;
   endfunction

   // Cycle counter and run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("matrix_chain_min_cost_core regression: fail");
         $finish;
      end
   end

   // Driver: next dimension word once the current one is taken
   always @(posedge clock) begin
      dim_word_type w;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (dim_words_pending.size() != 0 && !idle_now()) begin
            w = dim_words_pending.pop_front();
            req_chan.valid          <= 1'b1;
            req_chan.dimension      <= w.dimension;
            req_chan.last_dimension <= w.last_dimension;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Result-side ready: random idling plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (holdoff_left != 0) begin
         holdoff_left   <= holdoff_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (!holdoff_done && rsp_words_seen >= 40) begin
         holdoff_left   <= HOLDOFF_LEN;
         holdoff_done   <= 1'b1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= !idle_now();
      end
   end

   // Monitor: predict on accepted dimensions, check accepted cost words
   always @(posedge clock) begin
      cost_word_type w;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            take_dimension(req_chan.dimension, req_chan.last_dimension);
         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_words_seen <= rsp_words_seen + 1;
            if (cost_words_due.size() == 0) begin
               report_mismatch($sformatf("unexpected word cost=%0d status=%0d",
                                         rsp_chan.min_cost, rsp_chan.status));
            end else begin
               w = cost_words_due.pop_front();
               if (rsp_chan.min_cost !== w.min_cost)
                  report_mismatch($sformatf("min_cost got %0d want %0d",
                                            rsp_chan.min_cost, w.min_cost));
               if (rsp_chan.status !== w.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp_chan.status, w.status));
            end
         end
      end
   end

   // Stimulus, reset and end of run
   initial begin
      int i;
      reset                   = 1'b1;
      req_chan.valid          = 1'b0;
      req_chan.dimension      = '0;
      req_chan.last_dimension = 1'b0;
      rsp_chan.ready          = 1'b0;
      chain_len               = 0;
      chain_truncated         = 1'b0;
      mismatch_count          = 0;
      rsp_words_seen          = 0;
      cycle_count             = 0;
      holdoff_left            = 0;
      holdoff_done            = 1'b0;
      words_queued            = 0;

      // Single dimension: too few
      add_word(7, 1'b1);
      // Two dimensions, one zero: one matrix, no cost
      add_word(0, 1'b0);
      add_word(1023, 1'b1);
      // Zero inside a chain kills some products
      add_word(1023, 1'b0);
      add_word(0, 1'b0);
      add_word(1023, 1'b0);
      add_word(1, 1'b1);
      // Full chain of largest dimensions plus one dropped: max cost, too many
      for (i = 0; i < MAX_DIMS + 1; i++) add_word(1023, i == MAX_DIMS);

      while (words_queued < ITEM_TARGET) add_random_chain();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (dim_words_pending.size() != 0 || req_chan.valid) @(negedge clock);
      while (cost_words_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0)
         $display("matrix_chain_min_cost_core regression: pass");
      else
         $display("matrix_chain_min_cost_core regression: fail");
      $finish;
   end

endmodule
